[hw/rtl/rmrpy_pkg.sv]
// Shared constants and types for the rotation matrix to roll-pitch-yaw converter.
// No dependencies; the CORDIC, core and bench files take names from here by scope.
package rmrpy_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int GUARD_BITS   = 12;

  // 1/K in Q0.32, used as two 16-bit halves
  localparam logic [15:0] INV_GAIN_HI = 16'h9B74;
  localparam logic [15:0] INV_GAIN_LO = 16'hEDA8;

  // 32-bit binary angles, 2^32 = 2*pi
  localparam logic [31:0] Z_ZERO  = 32'h0000_0000;
  localparam logic [31:0] Z_PI    = 32'h8000_0000;
  localparam logic [31:0] Z_HALF  = 32'h4000_0000;
  localparam logic [31:0] Z_NHALF = 32'hC000_0000;

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // exact-axis cases that override the iterated angle
  typedef enum logic [2:0] {
    AX_NONE,
    AX_ZERO,
    AX_PI,
    AX_POS,
    AX_NEG
  } axis_t;

  typedef enum logic [1:0] {
    LOCK_NONE = 2'd0,
    LOCK_POS  = 2'd1,
    LOCK_NEG  = 2'd2
  } lock_kind_t;

  // register index decoded from paddr[2]
  localparam logic REG_THRESHOLD = 1'b0;

endpackage

[hw/rtl/rmrpy_if.sv]
// Valid/ready channel interfaces for matrix items and angle items.
// Depends on nothing; matrix and angle widths follow the DW parameter.
interface rmrpy_mat_if #(parameter int DW = 16);
  logic          valid;
  logic          ready;
  logic [DW-1:0] m00;
  logic [DW-1:0] m10;
  logic [DW-1:0] m20;
  logic [DW-1:0] m01;
  logic [DW-1:0] m11;
  logic [DW-1:0] m21;
  logic [DW-1:0] m22;
  modport source (output valid, m00, m10, m20, m01, m11, m21, m22, input ready);
  modport sink (input valid, m00, m10, m20, m01, m11, m21, m22, output ready);
endinterface

interface rmrpy_rpy_if #(parameter int DW = 16);
  logic          valid;
  logic          ready;
  logic [DW-1:0] angle_z;
  logic [DW-1:0] angle_y;
  logic [DW-1:0] angle_x;
  logic [1:0]    lock_kind;
  modport source (output valid, angle_z, angle_y, angle_x, lock_kind, input ready);
  modport sink (input valid, angle_z, angle_y, angle_x, lock_kind, output ready);
endinterface

[hw/rtl/rmrpy_cordic.sv]
// Pipelined vectoring CORDIC: one register stage for quadrant fold, one per micro-rotation.
// Uses rmrpy_pkg for the angle table and axis codes; carries a sideband word along.
module rmrpy_cordic #(
  parameter int DW  = 16,
  parameter int SBW = 1
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [DW:0]   x_in,
  input  logic signed [DW:0]   y_in,
  input  logic [SBW-1:0]       sb_in,
  output logic [DW+rmrpy_pkg::GUARD_BITS+2:0] mag_out,
  output logic [DW-1:0]        ang_out,
  output logic [SBW-1:0]       sb_out
);

  localparam int W  = DW + rmrpy_pkg::GUARD_BITS + 3;
  localparam int NS = rmrpy_pkg::CORDIC_STEPS + 1;
  localparam int SH = 32 - DW;
  localparam logic [31:0] ROUND = (32'd1 << SH) >> 1;

  logic signed [W-1:0] xr [NS];
  logic signed [W-1:0] yr [NS];
  logic [31:0]         zr [NS];
  rmrpy_pkg::axis_t    ar [NS];
  logic [SBW-1:0]      sr [NS];

  rmrpy_pkg::axis_t    axis;
  logic signed [W-1:0] xe;
  logic signed [W-1:0] ye;
  logic [31:0]         zfix;
  logic [31:0]         zsum;

  always_comb begin
    if (y_in == '0 && x_in >= 0) begin
      axis = rmrpy_pkg::AX_ZERO;
    end else if (y_in == '0) begin
      axis = rmrpy_pkg::AX_PI;
    end else if (x_in == '0 && y_in > 0) begin
      axis = rmrpy_pkg::AX_POS;
    end else if (x_in == '0) begin
      axis = rmrpy_pkg::AX_NEG;
    end else begin
      axis = rmrpy_pkg::AX_NONE;
    end
    xe = W'(x_in);
    ye = W'(y_in);
  end

  // fold the left half plane onto the right and start its angle at pi, else at zero
  always_ff @(posedge clk) begin
    if (en) begin
      if (x_in < 0) begin
        xr[0] <= (-xe) <<< rmrpy_pkg::GUARD_BITS;
        yr[0] <= (-ye) <<< rmrpy_pkg::GUARD_BITS;
        zr[0] <= rmrpy_pkg::Z_PI;
      end else begin
        xr[0] <= xe <<< rmrpy_pkg::GUARD_BITS;
        yr[0] <= ye <<< rmrpy_pkg::GUARD_BITS;
        zr[0] <= rmrpy_pkg::Z_ZERO;
      end
      ar[0] <= axis;
      sr[0] <= sb_in;
    end
  end

  for (genvar i = 0; i < rmrpy_pkg::CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (!yr[i][W-1]) begin
          xr[i+1] <= xr[i] + (yr[i] >>> i);
          yr[i+1] <= yr[i] - (xr[i] >>> i);
          zr[i+1] <= zr[i] + rmrpy_pkg::ATAN_TAB[i];
        end else begin
          xr[i+1] <= xr[i] - (yr[i] >>> i);
          yr[i+1] <= yr[i] + (xr[i] >>> i);
          zr[i+1] <= zr[i] - rmrpy_pkg::ATAN_TAB[i];
        end
        ar[i+1] <= ar[i];
        sr[i+1] <= sr[i];
      end
    end
  end

  always_comb begin
    case (ar[NS-1])
      rmrpy_pkg::AX_ZERO: zfix = rmrpy_pkg::Z_ZERO;
      rmrpy_pkg::AX_PI:   zfix = rmrpy_pkg::Z_PI;
      rmrpy_pkg::AX_POS:  zfix = rmrpy_pkg::Z_HALF;
      rmrpy_pkg::AX_NEG:  zfix = rmrpy_pkg::Z_NHALF;
      default:            zfix = zr[NS-1];
    endcase
    zsum = zfix + ROUND;
  end

  assign ang_out = zsum[31 -: DW];
  assign mag_out = $unsigned(xr[NS-1]);
  assign sb_out  = sr[NS-1];

endmodule

[hw/rtl/rotation_matrix_to_rpy_core.sv]
// Throughput is one item per cycle as long as the output skid slot is empty.
// The depth is two 25-stage CORDIC pipelines plus three gain/decision stages, and the
// output register; the first CORDIC stage loads at the accept edge.
// The pipeline advances unless the output skid slot is full, so one item keeps
// entering while a result waits. rst clears valid bits and sets the threshold to 3.
// Depends on rmrpy_pkg, rmrpy_mat_if / rmrpy_rpy_if and rmrpy_cordic.
module rotation_matrix_to_rpy_core #(
  parameter int DATA_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  rmrpy_mat_if.sink   mat,
  rmrpy_rpy_if.source rpy,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DW   = DATA_WIDTH;
  localparam int IW   = DW + 1;
  localparam int W    = DW + rmrpy_pkg::GUARD_BITS + 3;
  localparam int PW   = W + 17;
  localparam int NCS  = rmrpy_pkg::CORDIC_STEPS + 1;
  localparam int NS   = 2 * NCS + 3;
  localparam int SBA  = 5 * DW;
  localparam int CSH  = 16 + rmrpy_pkg::GUARD_BITS;
  localparam logic [PW-1:0] CRND   = PW'(1) << (CSH - 1);
  localparam logic [PW-1:0] MAXPOS = (PW'(1) << (DW - 1)) - PW'(1);
  localparam logic [DW-1:0] QUARTER = DW'(1) << (DW - 2);

  // configuration
  logic [DW-2:0] thr;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == rmrpy_pkg::REG_THRESHOLD) ? 32'(thr) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= (DW-1)'(3);
    end else if (psel && penable && pwrite && paddr[2] == rmrpy_pkg::REG_THRESHOLD) begin
      thr <= pwdata[DW-2:0];
    end
  end

  // pipeline control
  logic          en;
  logic [NS-1:0] v;
  logic          skid_v;

  assign en        = !skid_v;
  assign mat.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NS-2:0], mat.valid};
    end
  end

  // first CORDIC: angle_z and magnitude of (m00, m10)
  logic [W-1:0]   a_mag;
  logic [DW-1:0]  a_ang;
  logic [SBA-1:0] a_sb;

  rmrpy_cordic #(.DW(DW), .SBW(SBA)) u_cordic_z (
    .clk    (clk),
    .en     (en),
    .x_in   (IW'($signed(mat.m00))),
    .y_in   (IW'($signed(mat.m10))),
    .sb_in  ({mat.m20, mat.m01, mat.m11, mat.m21, mat.m22}),
    .mag_out(a_mag),
    .ang_out(a_ang),
    .sb_out (a_sb)
  );

  // gain compensation: products, then sum/round/saturate
  logic [W+15:0]  g1_phi;
  logic [W-1:0]   g1_plo;
  logic [SBA-1:0] g1_sb;
  logic [DW-1:0]  g1_az;
  logic [DW-2:0]  g2_cos;
  logic [SBA-1:0] g2_sb;
  logic [DW-1:0]  g2_az;
  logic [PW-1:0]  psum;
  logic [PW-1:0]  cfull;

  always_ff @(posedge clk) begin
    if (en) begin
      g1_phi <= (W+16)'(a_mag) * (W+16)'(rmrpy_pkg::INV_GAIN_HI);
      g1_plo <= W'(((W+16)'(a_mag) * (W+16)'(rmrpy_pkg::INV_GAIN_LO)) >> 16);
      g1_sb  <= a_sb;
      g1_az  <= a_ang;
    end
  end

  always_comb begin
    psum  = PW'(g1_phi) + PW'(g1_plo);
    cfull = (psum + CRND) >> CSH;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g2_cos <= (cfull > MAXPOS) ? MAXPOS[DW-2:0] : cfull[DW-2:0];
      g2_sb  <= g1_sb;
      g2_az  <= g1_az;
    end
  end

  // lock decision and operand selection for the second pair of CORDICs
  logic signed [DW-1:0] s_m20, s_m01, s_m11, s_m21, s_m22;
  logic signed [IW-1:0] sbv;
  logic                 lock;
  rmrpy_pkg::lock_kind_t kind;

  logic signed [IW-1:0] d_by, d_bx, d_cy, d_cx;
  logic [DW+1:0]        d_sb;

  always_comb begin
    {s_m20, s_m01, s_m11, s_m21, s_m22} = g2_sb;
    sbv  = -IW'(s_m20);
    lock = (g2_cos < thr) && (s_m20 != '0);
    if (!lock) begin
      kind = rmrpy_pkg::LOCK_NONE;
    end else if (s_m20[DW-1]) begin
      kind = rmrpy_pkg::LOCK_POS;
    end else begin
      kind = rmrpy_pkg::LOCK_NEG;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_by <= sbv;
      d_bx <= $signed(IW'(g2_cos));
      case (kind)
        rmrpy_pkg::LOCK_POS: begin
          d_cy <= IW'(s_m01);
          d_cx <= IW'(s_m11);
        end
        rmrpy_pkg::LOCK_NEG: begin
          d_cy <= -IW'(s_m01);
          d_cx <= IW'(s_m11);
        end
        default: begin
          d_cy <= IW'(s_m21);
          d_cx <= IW'(s_m22);
        end
      endcase
      d_sb <= {kind, g2_az};
    end
  end

  // angle_y and angle_x CORDICs run side by side
  logic [W-1:0]  b_mag, c_mag;
  logic [DW-1:0] b_ang, c_ang;
  logic [DW+1:0] b_sb;
  logic [0:0]    c_sb;

  rmrpy_cordic #(.DW(DW), .SBW(DW+2)) u_cordic_y (
    .clk    (clk),
    .en     (en),
    .x_in   (d_bx),
    .y_in   (d_by),
    .sb_in  (d_sb),
    .mag_out(b_mag),
    .ang_out(b_ang),
    .sb_out (b_sb)
  );

  rmrpy_cordic #(.DW(DW), .SBW(1)) u_cordic_x (
    .clk    (clk),
    .en     (en),
    .x_in   (d_cx),
    .y_in   (d_cy),
    .sb_in  (1'b0),
    .mag_out(c_mag),
    .ang_out(c_ang),
    .sb_out (c_sb)
  );

  // final override, then output register with one skid slot
  rmrpy_pkg::lock_kind_t f_kind;
  logic [DW-1:0] f_z, f_y, f_x;
  logic          p_v;

  assign p_v = v[NS-1];

  always_comb begin
    f_kind = rmrpy_pkg::lock_kind_t'(b_sb[DW+1:DW]);
    f_x    = c_ang;
    case (f_kind)
      rmrpy_pkg::LOCK_POS: begin
        f_z = '0;
        f_y = QUARTER;
      end
      rmrpy_pkg::LOCK_NEG: begin
        f_z = '0;
        f_y = -QUARTER;
      end
      default: begin
        f_z = b_sb[DW-1:0];
        f_y = b_ang;
      end
    endcase
  end

  logic          out_v;
  logic [DW-1:0] out_z, out_y, out_x;
  logic [1:0]    out_k;
  logic [DW-1:0] sk_z, sk_y, sk_x;
  logic [1:0]    sk_k;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (rpy.ready || !out_v) begin
      if (skid_v) begin
        out_v  <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        out_v  <= p_v;
      end
    end else if (p_v && en) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rpy.ready || !out_v) begin
      if (skid_v) begin
        out_z <= sk_z;
        out_y <= sk_y;
        out_x <= sk_x;
        out_k <= sk_k;
      end else begin
        out_z <= f_z;
        out_y <= f_y;
        out_x <= f_x;
        out_k <= f_kind;
      end
    end else if (en) begin
      sk_z <= f_z;
      sk_y <= f_y;
      sk_x <= f_x;
      sk_k <= f_kind;
    end
  end

  assign rpy.valid     = out_v;
  assign rpy.angle_z   = out_z;
  assign rpy.angle_y   = out_y;
  assign rpy.angle_x   = out_x;
  assign rpy.lock_kind = out_k;

`ifndef SYNTHESIS
  a_reset_clears: assert property (@(posedge clk) rst |=> !rpy.valid)
    else $error("result valid right after reset");
  a_lock_zero_z: assert property (@(posedge clk) disable iff (rst)
    rpy.valid && rpy.lock_kind != rmrpy_pkg::LOCK_NONE |-> rpy.angle_z == '0)
    else $error("gimbal lock with nonzero angle_z");
  a_lock_code: assert property (@(posedge clk) disable iff (rst)
    rpy.valid |-> (rpy.lock_kind == rmrpy_pkg::LOCK_NONE ||
                   rpy.lock_kind == rmrpy_pkg::LOCK_POS ||
                   rpy.lock_kind == rmrpy_pkg::LOCK_NEG))
    else $error("undefined lock_kind code");
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_v && !$past(rpy.ready))
    else $error("skid slot filled without a stalled result");
`endif

endmodule

[tb/sv/tb_top.sv]
// Self-checking bench for rotation_matrix_to_rpy_core: matrix items in, angle items out.
// Depends on rmrpy_pkg and the rmrpy_mat_if / rmrpy_rpy_if channel interfaces.
// Angles are predicted by a bit-exact CORDIC model kept inside this file.
module tb_top;

  typedef struct {
    logic signed [15:0] m00, m10, m20, m01, m11, m21, m22;
  } matrix_t;

  typedef struct {
    logic [15:0] az, ay, ax;
    rmrpy_pkg::lock_kind_t kind;
  } rpy_t;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  rmrpy_mat_if #(.DW(16)) mat_ch ();
  rmrpy_rpy_if #(.DW(16)) rpy_ch ();

  rotation_matrix_to_rpy_core #(.DATA_WIDTH(16)) i_dut (
    .clk(clk), .rst(rst), .mat(mat_ch.sink), .rpy(rpy_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  rpy_t        angles_due[$];
  logic [14:0] threshold;
  int          mismatches, items_sent, results_seen, locks_seen;
  int          rx_hold;
  bit          idle_on;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // ---------------- predictor ----------------
  function automatic longint cordic_vec(longint x, longint y, output logic [31:0] z);
    longint dx, dy;
    z = rmrpy_pkg::Z_ZERO;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = rmrpy_pkg::Z_PI;
    end
    x = x * (longint'(1) << rmrpy_pkg::GUARD_BITS);
    y = y * (longint'(1) << rmrpy_pkg::GUARD_BITS);
    for (int i = 0; i < rmrpy_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + rmrpy_pkg::ATAN_TAB[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - rmrpy_pkg::ATAN_TAB[i];
      end
    end
    return x;
  endfunction

  function automatic logic [31:0] bin_angle(longint y, longint x, output longint mag);
    logic [31:0] z;
    mag = cordic_vec(x, y, z);
    if (y == 0 && x > 0) z = rmrpy_pkg::Z_ZERO;
    else if (y == 0 && x < 0) z = rmrpy_pkg::Z_PI;
    else if (x == 0 && y > 0) z = rmrpy_pkg::Z_HALF;
    else if (x == 0 && y < 0) z = rmrpy_pkg::Z_NHALF;
    return z;
  endfunction

  function automatic logic [15:0] angle16(logic [31:0] z);
    logic [31:0] t;
    t = z + 32'h0000_8000;
    return t[31:16];
  endfunction

  function automatic longint cosine_q15(longint mag);
    longint p, c;
    p = mag * longint'(rmrpy_pkg::INV_GAIN_HI) +
        ((mag * longint'(rmrpy_pkg::INV_GAIN_LO)) >>> 16);
    c = (p + (longint'(1) << 27)) >>> 28;
    return (c > 32767) ? 32767 : c;
  endfunction

  function automatic rpy_t predict_rpy(matrix_t m, logic [14:0] thr);
    rpy_t   r;
    longint mag, dummy, cosv, sb;
    logic [31:0] az, ay, ax;
    az   = bin_angle(m.m10, m.m00, mag);
    cosv = cosine_q15(mag);
    sb   = -longint'(m.m20);
    if (cosv < longint'(thr) && sb > 0) begin
      az = rmrpy_pkg::Z_ZERO;
      ay = rmrpy_pkg::Z_HALF;
      ax = bin_angle(m.m01, m.m11, dummy);
      r.kind = rmrpy_pkg::LOCK_POS;
    end else if (cosv < longint'(thr) && sb < 0) begin
      az = rmrpy_pkg::Z_ZERO;
      ay = rmrpy_pkg::Z_NHALF;
      ax = bin_angle(-longint'(m.m01), m.m11, dummy);
      r.kind = rmrpy_pkg::LOCK_NEG;
    end else begin
      ay = bin_angle(sb, cosv, dummy);
      ax = bin_angle(m.m21, m.m22, dummy);
      r.kind = rmrpy_pkg::LOCK_NONE;
    end
    r.az = angle16(az);
    r.ay = angle16(ay);
    r.ax = angle16(ax);
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  task automatic send_matrix(matrix_t m);
    int gap;
    mat_ch.valid <= 1'b1;
    mat_ch.m00 <= m.m00; mat_ch.m10 <= m.m10; mat_ch.m20 <= m.m20;
    mat_ch.m01 <= m.m01; mat_ch.m11 <= m.m11; mat_ch.m21 <= m.m21;
    mat_ch.m22 <= m.m22;
    do @(posedge clk); while (!mat_ch.ready);
    angles_due.push_back(predict_rpy(m, threshold));
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      mat_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    mat_ch.valid <= 1'b0;
    while (angles_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // block must be idle; setup cycle then access cycle
  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr[2] == rmrpy_pkg::REG_THRESHOLD) threshold = data[14:0];
  endtask

  function automatic logic signed [15:0] to_q15(real v);
    real s;
    s = v * 32768.0;
    s = (s >= 0.0) ? s + 0.5 : s - 0.5;
    if (s > 32767.0) return 16'sd32767;
    if (s < -32768.0) return -16'sd32768;
    return 16'(int'($rtoi(s)));
  endfunction

  function automatic matrix_t rot_matrix(real yaw, real pitch, real roll, int noise);
    matrix_t m;
    real cy, sy, cp, sp, cr, sr;
    cy = $cos(yaw); sy = $sin(yaw); cp = $cos(pitch); sp = $sin(pitch);
    cr = $cos(roll); sr = $sin(roll);
    m.m00 = to_q15(cy * cp + noise * 1.0e-5 * ($urandom_range(0, 200) - 100.0));
    m.m10 = to_q15(sy * cp + noise * 1.0e-5 * ($urandom_range(0, 200) - 100.0));
    m.m20 = to_q15(-sp);
    m.m01 = to_q15(cy * sp * sr - sy * cr);
    m.m11 = to_q15(sy * sp * sr + cy * cr);
    m.m21 = to_q15(cp * sr);
    m.m22 = to_q15(cp * cr);
    return m;
  endfunction

  function automatic real rand_angle();
    return ($urandom_range(0, 1_000_000) / 1_000_000.0 * 2.0 - 1.0) * 3.14159265;
  endfunction

  function automatic matrix_t rand_matrix();
    matrix_t m;
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return rot_matrix(rand_angle(), rand_angle() / 2.0, rand_angle(), 0);
    if (r < 82) begin
      // pitch near +/- pi/2, small cosine
      m = rot_matrix(rand_angle(), ($urandom_range(0, 1) ? 1.0 : -1.0) *
                     (1.5707963 - $urandom_range(0, 400) * 1.0e-6), rand_angle(), 1);
      if ($urandom_range(0, 3) == 0) begin
        m.m00 = 16'($signed($urandom_range(0, 8)) - 4);
        m.m10 = 16'($signed($urandom_range(0, 8)) - 4);
      end
      return m;
    end
    m.m00 = 16'($urandom); m.m10 = 16'($urandom); m.m20 = 16'($urandom);
    m.m01 = 16'($urandom); m.m11 = 16'($urandom); m.m21 = 16'($urandom);
    m.m22 = 16'($urandom);
    return m;
  endfunction

  function automatic matrix_t mk(int a, int b, int c, int d, int e, int f, int g);
    matrix_t m;
    m.m00 = 16'(a); m.m10 = 16'(b); m.m20 = 16'(c); m.m01 = 16'(d);
    m.m11 = 16'(e); m.m21 = 16'(f); m.m22 = 16'(g);
    return m;
  endfunction

  // ---------------- result side ----------------
  initial begin
    rpy_ch.ready <= 1'b0;
    forever begin
      int stall;
      @(posedge clk);
      if (rx_hold > 0) begin
        rx_hold--;
        rpy_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        rpy_ch.ready <= 1'b0;
      end else begin
        rpy_ch.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 9) == 0) stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    rpy_t e;
    if (!rst && rpy_ch.valid && rpy_ch.ready) begin
      results_seen++;
      if (angles_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected angle item z=%0d", $signed(rpy_ch.angle_z));
      end else begin
        e = angles_due.pop_front();
        if (e.kind != rmrpy_pkg::LOCK_NONE) locks_seen++;
        if (rpy_ch.angle_z !== e.az || rpy_ch.angle_y !== e.ay ||
            rpy_ch.angle_x !== e.ax || rpy_ch.lock_kind !== e.kind) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp z/y/x/k %0d %0d %0d %0d got %0d %0d %0d %0d",
                     $signed(e.az), $signed(e.ay), $signed(e.ax), e.kind,
                     $signed(rpy_ch.angle_z), $signed(rpy_ch.angle_y),
                     $signed(rpy_ch.angle_x), rpy_ch.lock_kind);
        end
      end
    end
  end

  // ---------------- tests ----------------
  task automatic test_directed();
    matrix_t d[$];
    d.push_back(mk(32767, 0, 0, 0, 32767, 0, 32767));
    d.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
    d.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767));
    d.push_back(mk(0, 0, 0, 0, 0, 0, 0));
    d.push_back(mk(0, 0, -32768, 20000, 15000, 0, 0));      // lock, plus pi/2
    d.push_back(mk(0, 0, 32767, 20000, -15000, 0, 0));      // lock, minus pi/2
    d.push_back(mk(1, 1, -32767, -32768, 0, 0, 0));         // lock, cosine tiny
    d.push_back(mk(0, 0, 0, 1000, 1000, 0, 0));             // small cosine, m20 zero
    d.push_back(mk(-32768, 0, 0, 0, -32768, 0, -32768));    // yaw at pi
    d.push_back(mk(0, 32767, 0, -32768, 0, 32767, 0));      // yaw +pi/2
    d.push_back(mk(0, -32768, 0, 32767, 0, -32768, 0));     // yaw -pi/2
    d.push_back(mk(-32768, 0, 0, 0, 0, 0, -32768));         // roll at pi
    d.push_back(mk(32767, 32767, -32768, 0, 0, 32767, -1));
    d.push_back(mk(-1, -1, 1, -1, -1, -1, -1));
    d.push_back(mk(2, 0, -32768, 0, 0, 0, 0));              // cosine near threshold
    d.push_back(mk(4, 0, 32767, 0, 0, 0, 0));
    d.push_back(mk(12345, -23456, 5000, -32768, 32767, 100, -100));
    foreach (d[i]) send_matrix(d[i]);
    drain();
  endtask

  task automatic test_threshold_sweep();
    logic [31:0] vals[$];
    vals = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_7FFF, 32'hABCD_0010, 32'h0000_0400};
    foreach (vals[i]) begin
      write_reg(3'd0, vals[i]);
      for (int k = 0; k < 12; k++) send_matrix(rand_matrix());
      send_matrix(mk(0, 0, -32768, 300, 200, 0, 0));
      send_matrix(mk(1000, 0, 32767, 300, 200, 0, 0));
      drain();
    end
    write_reg(3'd4, 32'h0000_1234);   // unmapped register, must not take effect
    for (int k = 0; k < 8; k++) send_matrix(rand_matrix());
    drain();
  endtask

  task automatic test_random_stream();
    for (int blk = 0; blk < 5; blk++) begin
      idle_on = (blk != 2);
      write_reg(3'd0, (blk == 0) ? 32'd3 : {$urandom} & ((blk == 4) ? 32'h0000_7FFF : 32'h3FF));
      for (int k = 0; k < 300; k++) send_matrix(rand_matrix());
      drain();
    end
    idle_on = 1;
  endtask

  task automatic test_backpressure();
    rx_hold = 250;
    for (int k = 0; k < 120; k++) send_matrix(rand_matrix());
    drain();
  endtask

  initial begin
    rst = 1'b1;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    mat_ch.valid <= 1'b0;
    mat_ch.m00 <= '0; mat_ch.m10 <= '0; mat_ch.m20 <= '0; mat_ch.m01 <= '0;
    mat_ch.m11 <= '0; mat_ch.m21 <= '0; mat_ch.m22 <= '0;
    threshold = 15'd3;
    idle_on = 1;
    rx_hold = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_threshold_sweep();
    test_random_stream();
    test_backpressure();
    $display("run: %0d matrices sent, %0d angle items checked, %0d in gimbal lock",
             items_sent, results_seen, locks_seen);
    $display("run: threshold extremes, unmapped write, long output stall, %0d mismatches",
             mismatches);
    if (mismatches == 0 && angles_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
